### hw/rtl/bpc_pkg.sv
// Package for the barometer pressure compensation core.
// Widths, register indexes and the calibration struct shared by all RTL files.
// No dependencies.
`default_nettype none

package bpc_pkg;

  // Port widths
  localparam int RAW_W     = 24;  // raw conversions
  localparam int CAL_W     = 16;  // calibration words
  localparam int CFG_IDX_W = 3;   // register index
  localparam int OUT_W     = 24;  // compensated pressure

  // Internal widths, sized to the value ranges
  localparam int DT_W    = RAW_W + 1;       // temperature difference, signed
  localparam int MUL_W   = DT_W + CAL_W;    // dT * coefficient, signed
  localparam int TD_W    = MUL_W - 23;      // TEMP - 2000, signed
  localparam int TP_W    = TD_W + 1;        // TEMP + 1500, signed
  localparam int SQ_W    = 2 * TD_W - 1;    // squares, unsigned
  localparam int OFF1_W  = 35;              // first-order offset, signed
  localparam int SENS1_W = 34;              // first-order sensitivity, signed
  localparam int D5_W    = SQ_W + 3;        // 5 * d
  localparam int E7_W    = SQ_W + 3;        // 7 * e
  localparam int E11_W   = SQ_W + 4;        // 11 * e
  localparam int COR_W   = 39;              // OFF2 and SENS2, unsigned
  localparam int OFF_W   = 41;              // corrected offset, signed
  localparam int SENS_W  = 41;              // corrected sensitivity, signed
  localparam int SLO_W   = 24;              // low slice of SENS for the split multiply
  localparam int SHI_W   = SENS_W - SLO_W;  // high slice of SENS, signed
  localparam int LO_W    = RAW_W + SLO_W;   // low partial product, unsigned
  localparam int HI_W    = RAW_W + SHI_W;   // high partial product, signed
  localparam int PROD_W  = HI_W + SLO_W;    // D1 * SENS, signed
  localparam int DIFF_W  = PROD_W - 21 + 1; // (D1 * SENS >> 21) - OFF, signed
  localparam int P_W     = DIFF_W - 15;     // pressure before saturation

  // Number of register stages from input to result
  localparam int NUM_STAGES = 11;

  // Distance between the 20.00 C and -15.00 C thresholds, in 0.01 C
  localparam int TEMP_SPLIT = 3500;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_SENS  = 3'd0,
    REG_PRESS_OFF   = 3'd1,
    REG_SENS_TCO    = 3'd2,
    REG_OFF_TCO     = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } bpc_reg_e;

  // Calibration words
  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sens_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temp_word;
    logic [CAL_W-1:0] temp_slope_word;
  } bpc_cal_t;

endpackage

`default_nettype wire

### hw/rtl/bpc_cfg_regs.sv
// Calibration register file for the pressure compensation core.
// Depends on bpc_pkg.
`default_nettype none

module bpc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] idx_i,
  input  wire logic [bpc_pkg::CAL_W-1:0]     data_i,
  output bpc_pkg::bpc_cal_t                  cal_o
);
  import bpc_pkg::*;

  bpc_cal_t cal_q, cal_d;

  // Register decode; indexes past the list are dropped
  always_comb begin
    cal_d = cal_q;
    if (wr_en_i) begin
      unique case (idx_i)
        REG_PRESS_SENS: cal_d.pressure_sensitivity = data_i;
        REG_PRESS_OFF:  cal_d.pressure_offset      = data_i;
        REG_SENS_TCO:   cal_d.sens_temp_coeff      = data_i;
        REG_OFF_TCO:    cal_d.offset_temp_coeff    = data_i;
        REG_REF_TEMP:   cal_d.reference_temp_word  = data_i;
        REG_TEMP_SLOPE: cal_d.temp_slope_word      = data_i;
        default:        cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

  // A write to the reference temperature lands in the next cycle
  a_ref_temp_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && (idx_i == REG_REF_TEMP) |=> cal_q.reference_temp_word == $past(data_i))
    else $error("reference temperature write lost");

  // Writes beyond the register list leave every word alone
  a_unused_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && (idx_i != REG_PRESS_SENS) && (idx_i != REG_PRESS_OFF) &&
    (idx_i != REG_SENS_TCO) && (idx_i != REG_OFF_TCO) &&
    (idx_i != REG_REF_TEMP) && (idx_i != REG_TEMP_SLOPE) |=> $stable(cal_q))
    else $error("write to unused index changed calibration");

endmodule

`default_nettype wire

### hw/rtl/bpc_datapath.sv
// Eleven-stage compensation pipeline: dT, first-order terms, squares,
// second-order corrections, split D1 * SENS multiply, shift and saturation.
// Depends on bpc_pkg.
`default_nettype none

module bpc_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic [bpc_pkg::RAW_W-1:0]       raw_pressure_i,
  input  wire logic [bpc_pkg::RAW_W-1:0]       raw_temperature_i,
  input  wire bpc_pkg::bpc_cal_t               cal_i,
  output logic                                 out_valid_o,
  output logic signed [bpc_pkg::OUT_W-1:0]     pressure_pa_o
);
  import bpc_pkg::*;

  // Valid bit of each stage; bit 0 is stage 1
  logic [NUM_STAGES-1:0] vld_q, vld_d;

  // Stage 1: temperature difference
  logic [RAW_W-1:0]        d1_s1_q;
  logic signed [DT_W-1:0]  dt_s1_q, dt_s1_d;
  // Stage 2: dT products
  logic [RAW_W-1:0]        d1_s2_q;
  logic signed [MUL_W:0]   mt_full, mo_full, ms_full;
  logic signed [MUL_W-1:0] mt_s2_q, mo_s2_q, ms_s2_q;
  // Stage 3: first-order terms
  logic [RAW_W-1:0]          d1_s3_q;
  logic signed [TD_W-1:0]    td_s3_q, td_s3_d;
  logic signed [TP_W-1:0]    tp_s3_q, tp_s3_d;
  logic signed [OFF1_W-1:0]  off1_s3_q, off1_s3_d;
  logic signed [SENS1_W-1:0] sens1_s3_q, sens1_s3_d;
  // Stage 4: squares and range flags
  logic [RAW_W-1:0]            d1_s4_q;
  logic signed [OFF1_W-1:0]    off1_s4_q;
  logic signed [SENS1_W-1:0]   sens1_s4_q;
  logic signed [2*TD_W-1:0]    dsq_full;
  logic signed [2*TP_W-1:0]    esq_full;
  logic [SQ_W-1:0]             dsq_s4_q, esq_s4_q;
  logic                        low_s4_q, vlow_s4_q;
  // Stage 5: scaled squares, gated by range
  logic [RAW_W-1:0]          d1_s5_q;
  logic signed [OFF1_W-1:0]  off1_s5_q;
  logic signed [SENS1_W-1:0] sens1_s5_q;
  logic [D5_W-1:0]           d5_s5_q, d5_s5_d;
  logic [E7_W-1:0]           e7_s5_q, e7_s5_d;
  logic [E11_W-1:0]          e11_s5_q, e11_s5_d;
  // Stage 6: OFF2 and SENS2
  logic [RAW_W-1:0]          d1_s6_q;
  logic signed [OFF1_W-1:0]  off1_s6_q;
  logic signed [SENS1_W-1:0] sens1_s6_q;
  logic [COR_W-1:0]          off2_s6_q, off2_s6_d, sens2_s6_q, sens2_s6_d;
  // Stage 7: corrected OFF and SENS
  logic [RAW_W-1:0]         d1_s7_q;
  logic signed [OFF_W-1:0]  off_s7_q, off_s7_d;
  logic signed [SENS_W-1:0] sens_s7_q, sens_s7_d;
  // Stage 8: partial products
  logic signed [OFF_W-1:0]  off_s8_q;
  logic [LO_W-1:0]          lo_s8_q, lo_s8_d;
  logic signed [HI_W:0]     hi_full;
  logic signed [HI_W-1:0]   hi_s8_q;
  // Stage 9: full product
  logic signed [OFF_W-1:0]  off_s9_q;
  logic signed [PROD_W-1:0] prod_s9_q, prod_s9_d;
  // Stage 10: shifted product minus offset
  logic signed [DIFF_W-1:0] diff_s10_q, diff_s10_d;
  // Stage 11: saturated result
  logic [P_W-1:0]           p_s10;
  logic                     in_range, ovf_pos;
  logic signed [OUT_W-1:0]  pressure_q, pressure_d;

  // Valid bits travel with the data
  assign vld_d = {vld_q[NUM_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: dT = D2 - C5 * 256
  assign dt_s1_d = $signed({1'b0, raw_temperature_i})
                 - $signed({1'b0, cal_i.reference_temp_word, 8'b0});

  // Stage 2: three dT products in parallel
  assign mt_full = dt_s1_q * $signed({1'b0, cal_i.temp_slope_word});
  assign mo_full = dt_s1_q * $signed({1'b0, cal_i.offset_temp_coeff});
  assign ms_full = dt_s1_q * $signed({1'b0, cal_i.sens_temp_coeff});

  // Stage 3: arithmetic shifts are part-selects of the signed products
  assign td_s3_d    = mt_s2_q[MUL_W-1 -: TD_W];
  assign tp_s3_d    = $signed({td_s3_d[TD_W-1], td_s3_d}) + $signed(TP_W'(TEMP_SPLIT));
  assign off1_s3_d  = $signed({3'b0, cal_i.pressure_offset, 16'b0})
                    + $signed({mo_s2_q[MUL_W-1], mo_s2_q[MUL_W-1:7]});
  assign sens1_s3_d = $signed({3'b0, cal_i.pressure_sensitivity, 15'b0})
                    + $signed({ms_s2_q[MUL_W-1], ms_s2_q[MUL_W-1:8]});

  // Stage 4: squares of (TEMP - 2000) and (TEMP + 1500)
  assign dsq_full = td_s3_q * td_s3_q;
  assign esq_full = tp_s3_q * tp_s3_q;

  // Stage 5: 5d, 7e, 11e; zero where the correction does not apply
  always_comb begin
    d5_s5_d  = '0;
    e7_s5_d  = '0;
    e11_s5_d = '0;
    if (low_s4_q) begin
      d5_s5_d = {3'b0, dsq_s4_q} + {1'b0, dsq_s4_q, 2'b0};
      if (vlow_s4_q) begin
        e7_s5_d  = {esq_s4_q, 3'b0} - {3'b0, esq_s4_q};
        e11_s5_d = {1'b0, esq_s4_q, 3'b0} + {3'b0, esq_s4_q, 1'b0} + {4'b0, esq_s4_q};
      end
    end
  end

  // Stage 6: OFF2 = 5d/2 + 7e, SENS2 = 5d/4 + 11e/2
  assign off2_s6_d  = {2'b0, d5_s5_q[D5_W-1:1]} + {1'b0, e7_s5_q};
  assign sens2_s6_d = {3'b0, d5_s5_q[D5_W-1:2]} + {1'b0, e11_s5_q[E11_W-1:1]};

  // Stage 7: subtract the corrections
  assign off_s7_d  = $signed({{(OFF_W-OFF1_W){off1_s6_q[OFF1_W-1]}}, off1_s6_q})
                   - $signed({2'b0, off2_s6_q});
  assign sens_s7_d = $signed({{(SENS_W-SENS1_W){sens1_s6_q[SENS1_W-1]}}, sens1_s6_q})
                   - $signed({2'b0, sens2_s6_q});

  // Stage 8: D1 * SENS split into a low unsigned and a high signed slice
  assign lo_s8_d = d1_s7_q * sens_s7_q[SLO_W-1:0];
  assign hi_full = $signed({1'b0, d1_s7_q}) * $signed(sens_s7_q[SENS_W-1:SLO_W]);

  // Stage 9: recombine the partial products
  assign prod_s9_d = $signed({hi_s8_q, {SLO_W{1'b0}}})
                   + $signed({{(PROD_W-LO_W){1'b0}}, lo_s8_q});

  // Stage 10: (D1 * SENS >> 21) - OFF
  assign diff_s10_d = $signed({prod_s9_q[PROD_W-1], prod_s9_q[PROD_W-1:21]})
                    - $signed({{(DIFF_W-OFF_W){off_s9_q[OFF_W-1]}}, off_s9_q});

  // Stage 11: >> 15 and saturate to 24-bit signed
  assign p_s10    = diff_s10_q[DIFF_W-1:15];
  assign in_range = (&p_s10[P_W-1:OUT_W-1]) | ~(|p_s10[P_W-1:OUT_W-1]);
  assign ovf_pos  = !in_range && !p_s10[P_W-1];

  always_comb begin
    if (in_range) begin
      pressure_d = $signed(p_s10[OUT_W-1:0]);
    end else if (p_s10[P_W-1]) begin
      pressure_d = OUT_MIN;
    end else begin
      pressure_d = OUT_MAX;
    end
  end

  // Payload registers, loaded every cycle
  always_ff @(posedge clk_i) begin
    d1_s1_q    <= raw_pressure_i;
    dt_s1_q    <= dt_s1_d;

    d1_s2_q    <= d1_s1_q;
    mt_s2_q    <= mt_full[MUL_W-1:0];
    mo_s2_q    <= mo_full[MUL_W-1:0];
    ms_s2_q    <= ms_full[MUL_W-1:0];

    d1_s3_q    <= d1_s2_q;
    td_s3_q    <= td_s3_d;
    tp_s3_q    <= tp_s3_d;
    off1_s3_q  <= off1_s3_d;
    sens1_s3_q <= sens1_s3_d;

    d1_s4_q    <= d1_s3_q;
    off1_s4_q  <= off1_s3_q;
    sens1_s4_q <= sens1_s3_q;
    dsq_s4_q   <= dsq_full[SQ_W-1:0];
    esq_s4_q   <= esq_full[SQ_W-1:0];
    low_s4_q   <= td_s3_q[TD_W-1];
    vlow_s4_q  <= tp_s3_q[TP_W-1];

    d1_s5_q    <= d1_s4_q;
    off1_s5_q  <= off1_s4_q;
    sens1_s5_q <= sens1_s4_q;
    d5_s5_q    <= d5_s5_d;
    e7_s5_q    <= e7_s5_d;
    e11_s5_q   <= e11_s5_d;

    d1_s6_q    <= d1_s5_q;
    off1_s6_q  <= off1_s5_q;
    sens1_s6_q <= sens1_s5_q;
    off2_s6_q  <= off2_s6_d;
    sens2_s6_q <= sens2_s6_d;

    d1_s7_q    <= d1_s6_q;
    off_s7_q   <= off_s7_d;
    sens_s7_q  <= sens_s7_d;

    off_s8_q   <= off_s7_q;
    lo_s8_q    <= lo_s8_d;
    hi_s8_q    <= hi_full[HI_W-1:0];

    off_s9_q   <= off_s8_q;
    prod_s9_q  <= prod_s9_d;

    diff_s10_q <= diff_s10_d;

    pressure_q <= pressure_d;
  end

  assign out_valid_o   = vld_q[NUM_STAGES-1];
  assign pressure_pa_o = pressure_q;

  // Every result traces back to an item that entered the first stage
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(vld_q[0], NUM_STAGES - 1))
    else $error("result without a matching input");

  // Below -15 C implies below 20 C
  a_range_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && vlow_s4_q |-> low_s4_q)
    else $error("temperature range flags disagree");

  // Positive overflow saturates to the upper bound
  a_sat_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(vld_q[NUM_STAGES-2] && ovf_pos) |-> pressure_pa_o == OUT_MAX)
    else $error("positive overflow not saturated");

endmodule

`default_nettype wire

### hw/rtl/baro_pressure_compensation_core.sv
// Barometer second-order pressure compensation core, top level.
// A result strobes on done_o once its start_i item has passed every pipeline stage.
// Throughput: one item per cycle, set by the eleven-stage pipeline; busy_o stays low.
// The receiver cannot stall; each result is valid for exactly one cycle.
// Reset clears the pipeline valid bits and all calibration words to zero.
// Depends on bpc_pkg, bpc_cfg_regs and bpc_datapath.
`default_nettype none

module baro_pressure_compensation_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Command side
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [bpc_pkg::RAW_W-1:0]       raw_pressure_i,
  input  wire logic [bpc_pkg::RAW_W-1:0]       raw_temperature_i,
  // Result side
  output logic                                 done_o,
  output logic signed [bpc_pkg::OUT_W-1:0]     pressure_pa_o,
  // Configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bpc_pkg::CAL_W-1:0]       cfg_data_i
);
  import bpc_pkg::*;

  bpc_cal_t cal;
  logic     cfg_wr;
  logic     in_accept;

  // Fully pipelined: never busy, config always accepted
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign in_accept   = start_i && !busy_o;

  // Calibration registers
  bpc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_wr),
    .idx_i   (cfg_index_i),
    .data_i  (cfg_data_i),
    .cal_o   (cal)
  );

  // Compensation pipeline
  bpc_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_accept),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .cal_i             (cal),
    .out_valid_o       (done_o),
    .pressure_pa_o     (pressure_pa_o)
  );

  // Each accepted transaction yields a result after the pipeline depth
  a_start_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> ##(NUM_STAGES) done_o)
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
